### rtl/olg_pkg.sv
package olg_pkg;

  // Default geometry
  localparam int COORD_WIDTH_DEF = 32;
  localparam int EDGE_POINTS_DEF = 3;

  // Register widths
  localparam int BL_W      = 8;
  localparam int MD_W      = 20;
  localparam int ML_W      = 3;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [BL_W-1:0] BLOCK_LEN_RST  = 8'd10;
  localparam logic [MD_W-1:0] MAX_DIST_RST   = 20'd8192;
  localparam logic [ML_W-1:0] MISS_LIMIT_RST = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_M,
    S_DECIDE,
    S_HEAD,
    S_DIV_X_GO,
    S_DIV_X,
    S_DIV_Y_GO,
    S_DIV_Y,
    S_AVG,
    S_FLUSH
  } olg_state_t;

endpackage

### rtl/olg_in_if.sv
interface olg_in_if #(
  parameter int COORD_WIDTH = olg_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic                          last_in;

  modport source (output valid, x_in, y_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, last_in, output ready);
endinterface

### rtl/olg_out_if.sv
interface olg_out_if #(
  parameter int COORD_WIDTH = olg_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic                          is_average;
  logic                          last_out;

  modport source (output valid, x_out, y_out, is_average, last_out, input ready);
  modport sink   (input valid, x_out, y_out, is_average, last_out, output ready);
endinterface

### rtl/olg_div.sv
module olg_div #(
  parameter int DVD_W = olg_pkg::COORD_WIDTH_DEF + olg_pkg::BL_W,
  parameter int DVS_W = olg_pkg::BL_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      dvd <= dividend;
    end else if (busy) begin
      rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quotient = dvd;
endmodule

### rtl/track_outlier_gate_block_average.sv
// Track point outlier gate with block-average decimation.
// Points enter on pt_in (x_in, y_in, last_in; valid/ready) and results leave on
// pt_out (x_out, y_out, is_average, last_out; valid/ready). Registers are
// written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce this. The block
// works on one point at a time: pt_in.ready is high only while the sequencer
// waits for a point. The gate steps through a difference, three passes through
// one shared 20x20 multiplier and a decision; a passed-through point then waits
// in S_HEAD until the output register is free to take it. When a group of
// points closes, one serial divider produces the x then the y average at one
// quotient bit per cycle. On the final point of a track the held points leave
// at one per cycle while the receiver takes them, the last marked. A finished
// result waits in the output register while a new point is taken; when the
// receiver stalls with the register full, the sequencer waits at its next
// result. Reset restores the register defaults and clears all track state; no
// clearing pass is needed.
module track_outlier_gate_block_average #(
  parameter int EDGE_POINTS = olg_pkg::EDGE_POINTS_DEF,
  parameter int COORD_WIDTH = olg_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  olg_in_if.sink                         pt_in,
  olg_out_if.source                      pt_out,
  input  logic                           cfg_we,
  input  logic [olg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [olg_pkg::CFG_W-1:0]      cfg_data
);
  localparam int BL_W  = olg_pkg::BL_W;
  localparam int MD_W  = olg_pkg::MD_W;
  localparam int ML_W  = olg_pkg::ML_W;
  localparam int SUM_W = COORD_WIDTH + BL_W;
  localparam int CNT_W = $clog2(EDGE_POINTS + 1);
  localparam int DIF_W = COORD_WIDTH + 1;
  localparam int CMP_W = (DIF_W > MD_W) ? DIF_W : MD_W;
  localparam int SQ_W  = 2 * MD_W;

  olg_pkg::olg_state_t state, state_next;

  // Configuration registers
  logic [BL_W-1:0] block_len;
  logic [MD_W-1:0] max_dist;
  logic [ML_W-1:0] miss_limit;

  // Current point
  logic signed [COORD_WIDTH-1:0] px, py;
  logic                          plast;

  // Track state
  logic signed [COORD_WIDTH-1:0] ref_x, ref_y;
  logic                          have_ref;
  logic [ML_W-1:0]               miss_count;
  logic [CNT_W-1:0]              head_count;
  logic signed [COORD_WIDTH-1:0] hold_x [EDGE_POINTS];
  logic signed [COORD_WIDTH-1:0] hold_y [EDGE_POINTS];
  logic [CNT_W-1:0]              hold_fill;
  logic signed [SUM_W-1:0]       sum_x, sum_y;
  logic [BL_W-1:0]               group_count;

  // Gate datapath
  logic signed [DIF_W-1:0] dx, dy;
  logic [DIF_W-1:0]        adx, ady;
  logic [CMP_W-1:0]        ax_ext, ay_ext;
  logic [MD_W-1:0]         ax, ay;
  logic                    far;
  logic                    far_now;
  logic [MD_W-1:0]         mul_a;
  logic [SQ_W-1:0]         mul_p;
  logic [SQ_W-1:0]         prod;
  logic [SQ_W:0]           dist_acc;
  logic                    pass;
  logic                    accept;
  logic                    head_full;
  logic                    hold_full;
  logic [BL_W-1:0]         blk;
  logic [BL_W:0]           gc_inc;
  logic                    close;

  // Averaging
  logic                    div_start;
  logic [SUM_W-1:0]        div_dvd;
  logic [SUM_W-1:0]        div_q;
  logic [SUM_W-1:0]        div_q_neg;
  logic                    div_done;
  logic [SUM_W-1:0]        mag_x, mag_y;
  logic signed [COORD_WIDTH-1:0] avg_x, avg_y;

  // Output register
  logic                          o_valid;
  logic signed [COORD_WIDTH-1:0] o_x, o_y;
  logic                          o_avg, o_last;
  logic                          slot_free;
  logic                          emit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_len  <= olg_pkg::BLOCK_LEN_RST;
      max_dist   <= olg_pkg::MAX_DIST_RST;
      miss_limit <= olg_pkg::MISS_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        olg_pkg::CFG_BLOCK_LEN:  block_len  <= cfg_data[BL_W-1:0];
        olg_pkg::CFG_MAX_DIST:   max_dist   <= cfg_data[MD_W-1:0];
        olg_pkg::CFG_MISS_LIMIT: miss_limit <= cfg_data[ML_W-1:0];
        default: ;
      endcase
    end
  end

  // Distance to the reference, per axis
  assign dx      = {px[COORD_WIDTH-1], px} - {ref_x[COORD_WIDTH-1], ref_x};
  assign dy      = {py[COORD_WIDTH-1], py} - {ref_y[COORD_WIDTH-1], ref_y};
  assign adx     = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
  assign ady     = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
  assign ax_ext  = CMP_W'(adx);
  assign ay_ext  = CMP_W'(ady);
  assign far_now = (ax_ext >= CMP_W'(max_dist)) || (ay_ext >= CMP_W'(max_dist));

  // Shared squaring multiplier
  always_comb begin
    unique case (state)
      olg_pkg::S_MUL_X: mul_a = ax;
      olg_pkg::S_MUL_Y: mul_a = ay;
      default:          mul_a = max_dist;
    endcase
  end
  assign mul_p = mul_a * mul_a;

  // Gate decision and grouping
  assign pass      = !far && (dist_acc < {1'b0, prod});
  assign accept    = !have_ref || pass;
  assign head_full = head_count == CNT_W'(EDGE_POINTS);
  assign hold_full = hold_fill == CNT_W'(EDGE_POINTS);
  assign blk       = (block_len == '0) ? BL_W'(1) : block_len;
  assign gc_inc    = {1'b0, group_count} + (BL_W + 1)'(1);
  assign close     = hold_full && (gc_inc >= {1'b0, blk});

  // Divider operands
  assign mag_x     = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign mag_y     = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
  assign div_start = (state == olg_pkg::S_DIV_X_GO) || (state == olg_pkg::S_DIV_Y_GO);
  assign div_dvd   = (state == olg_pkg::S_DIV_Y_GO) ? mag_y : mag_x;
  assign div_q_neg = ~div_q + SUM_W'(1);

  olg_div #(
    .DVD_W (SUM_W),
    .DVS_W (BL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (group_count),
    .quotient (div_q),
    .done     (div_done)
  );

  assign slot_free = !o_valid || pt_out.ready;

  // Sequencer: next state and strobes
  always_comb begin
    state_next  = state;
    pt_in.ready = 1'b0;
    emit        = 1'b0;
    unique case (state)
      olg_pkg::S_IDLE: begin
        pt_in.ready = 1'b1;
        if (pt_in.valid) state_next = olg_pkg::S_DIFF;
      end
      olg_pkg::S_DIFF:  state_next = olg_pkg::S_MUL_X;
      olg_pkg::S_MUL_X: state_next = olg_pkg::S_MUL_Y;
      olg_pkg::S_MUL_Y: state_next = olg_pkg::S_MUL_M;
      olg_pkg::S_MUL_M: state_next = olg_pkg::S_DECIDE;
      olg_pkg::S_DECIDE: begin
        priority if (accept && !head_full) state_next = olg_pkg::S_HEAD;
        else if (accept && close)          state_next = olg_pkg::S_DIV_X_GO;
        else if (plast)                    state_next = olg_pkg::S_FLUSH;
        else                               state_next = olg_pkg::S_IDLE;
      end
      olg_pkg::S_HEAD, olg_pkg::S_AVG: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = plast ? olg_pkg::S_FLUSH : olg_pkg::S_IDLE;
        end
      end
      olg_pkg::S_DIV_X_GO: state_next = olg_pkg::S_DIV_X;
      olg_pkg::S_DIV_X: begin
        if (div_done) state_next = olg_pkg::S_DIV_Y_GO;
      end
      olg_pkg::S_DIV_Y_GO: state_next = olg_pkg::S_DIV_Y;
      olg_pkg::S_DIV_Y: begin
        if (div_done) state_next = olg_pkg::S_AVG;
      end
      olg_pkg::S_FLUSH: begin
        if (hold_fill == '0) begin
          state_next = olg_pkg::S_IDLE;
        end else if (slot_free) begin
          emit = 1'b1;
        end
      end
      default: state_next = olg_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= olg_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Track state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x       <= '0;
      ref_y       <= '0;
      have_ref    <= 1'b0;
      miss_count  <= '0;
      head_count  <= '0;
      hold_fill   <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      group_count <= '0;
    end else begin
      unique case (state)
        olg_pkg::S_DECIDE: begin
          if (accept) begin
            ref_x      <= px;
            ref_y      <= py;
            have_ref   <= 1'b1;
            miss_count <= '0;
            if (!head_full) begin
              head_count <= head_count + CNT_W'(1);
            end else if (hold_full) begin
              // oldest held point joins the running group
              sum_x       <= sum_x + SUM_W'(hold_x[0]);
              sum_y       <= sum_y + SUM_W'(hold_y[0]);
              group_count <= gc_inc[BL_W-1:0];
            end else begin
              hold_fill <= hold_fill + CNT_W'(1);
            end
          end else if (miss_count < miss_limit) begin
            miss_count <= miss_count + ML_W'(1);
          end else begin
            ref_x <= px;
            ref_y <= py;
          end
        end
        olg_pkg::S_AVG: begin
          if (emit) begin
            sum_x       <= '0;
            sum_y       <= '0;
            group_count <= '0;
          end
        end
        olg_pkg::S_FLUSH: begin
          if (hold_fill == '0) begin
            // end of track: drop partial group and forget the reference
            ref_x       <= '0;
            ref_y       <= '0;
            have_ref    <= 1'b0;
            miss_count  <= '0;
            head_count  <= '0;
            sum_x       <= '0;
            sum_y       <= '0;
            group_count <= '0;
          end else if (emit) begin
            hold_fill <= hold_fill - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: point capture, gate operands, delay line, averages
  always_ff @(posedge clk) begin
    if (state == olg_pkg::S_IDLE && pt_in.valid) begin
      px    <= pt_in.x_in;
      py    <= pt_in.y_in;
      plast <= pt_in.last_in;
    end
    if (state == olg_pkg::S_DIFF) begin
      ax  <= ax_ext[MD_W-1:0];
      ay  <= ay_ext[MD_W-1:0];
      far <= far_now;
    end
    if (state == olg_pkg::S_MUL_X || state == olg_pkg::S_MUL_Y ||
        state == olg_pkg::S_MUL_M) begin
      prod <= mul_p;
    end
    if (state == olg_pkg::S_MUL_Y) dist_acc <= {1'b0, prod};
    if (state == olg_pkg::S_MUL_M) dist_acc <= dist_acc + {1'b0, prod};

    // Delay line: append, or shift out the oldest
    if (state == olg_pkg::S_DECIDE && accept && head_full) begin
      for (int i = 0; i < EDGE_POINTS; i++) begin
        if (hold_full) begin
          if (i == EDGE_POINTS - 1) begin
            hold_x[i] <= px;
            hold_y[i] <= py;
          end else begin
            hold_x[i] <= hold_x[i+1];
            hold_y[i] <= hold_y[i+1];
          end
        end else if (CNT_W'(i) == hold_fill) begin
          hold_x[i] <= px;
          hold_y[i] <= py;
        end
      end
    end else if (state == olg_pkg::S_FLUSH && emit) begin
      for (int i = 0; i < EDGE_POINTS - 1; i++) begin
        hold_x[i] <= hold_x[i+1];
        hold_y[i] <= hold_y[i+1];
      end
    end

    // Signed averages, truncated toward zero
    if (state == olg_pkg::S_DIV_X && div_done) begin
      avg_x <= sum_x[SUM_W-1] ? div_q_neg[COORD_WIDTH-1:0] : div_q[COORD_WIDTH-1:0];
    end
    if (state == olg_pkg::S_DIV_Y && div_done) begin
      avg_y <= sum_y[SUM_W-1] ? div_q_neg[COORD_WIDTH-1:0] : div_q[COORD_WIDTH-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (pt_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (state)
        olg_pkg::S_HEAD: begin
          o_x    <= px;
          o_y    <= py;
          o_avg  <= 1'b0;
          o_last <= plast;
        end
        olg_pkg::S_AVG: begin
          o_x    <= avg_x;
          o_y    <= avg_y;
          o_avg  <= 1'b1;
          o_last <= 1'b0;
        end
        default: begin
          o_x    <= hold_x[0];
          o_y    <= hold_y[0];
          o_avg  <= 1'b0;
          o_last <= hold_fill == CNT_W'(1);
        end
      endcase
    end
  end

  assign pt_out.valid      = o_valid;
  assign pt_out.x_out      = o_x;
  assign pt_out.y_out      = o_y;
  assign pt_out.is_average = o_avg;
  assign pt_out.last_out   = o_last;
endmodule

### verif/track_outlier_gate_block_average_tb.sv
`timescale 1ns / 100ps

module track_outlier_gate_block_average_tb;

  localparam int EDGE_POINTS    = olg_pkg::EDGE_POINTS_DEF;
  localparam int BL_W           = olg_pkg::BL_W;
  localparam int MD_W           = olg_pkg::MD_W;
  localparam int ML_W           = olg_pkg::ML_W;
  localparam int CFG_W          = olg_pkg::CFG_W;
  localparam int CFG_IDX_W      = olg_pkg::CFG_IDX_W;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS    = 10;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               avg;
    logic               last;
  } track_pt_t;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  olg_in_if  pt_in ();
  olg_out_if pt_out ();

  track_outlier_gate_block_average dut (
    .clk       (clk),
    .rst       (rst),
    .pt_in     (pt_in),
    .pt_out    (pt_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Expected output points, oldest first
  track_pt_t expected_pts[$];
  int failures;
  int send_idle_pct;
  int sink_stall_pct;
  int hold_off_requests;

  // Predictor copy of the registers
  logic [BL_W-1:0] block_len_r;
  logic [MD_W-1:0] max_dist_r;
  logic [ML_W-1:0] miss_limit_r;

  // Predictor copy of the track state
  logic signed [31:0] anchor_x;
  logic signed [31:0] anchor_y;
  bit                 have_anchor;
  logic [2:0]         miss_cnt;
  int                 head_cnt;
  logic signed [31:0] hold_x [EDGE_POINTS];
  logic signed [31:0] hold_y [EDGE_POINTS];
  int                 hold_fill;
  longint             sum_x;
  longint             sum_y;
  int                 group_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_track();
    anchor_x    = '0;
    anchor_y    = '0;
    have_anchor = 1'b0;
    miss_cnt    = '0;
    head_cnt    = 0;
    hold_fill   = 0;
    sum_x       = 0;
    sum_y       = 0;
    group_cnt   = 0;
  endfunction

  // Squared distance gate against the anchor point
  function automatic bit gate_accepts(logic signed [31:0] px, logic signed [31:0] py);
    longint dx;
    longint dy;
    longint md;
    dx = longint'(px) - longint'(anchor_x);
    dy = longint'(py) - longint'(anchor_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    md = longint'({44'd0, max_dist_r});
    if (dx >= md || dy >= md) return 1'b0;
    return (dx * dx + dy * dy) < (md * md);
  endfunction

  function automatic void push_point(logic signed [31:0] px, logic signed [31:0] py,
                                     logic is_avg);
    track_pt_t pt;
    pt.x    = px;
    pt.y    = py;
    pt.avg  = is_avg;
    pt.last = 1'b0;
    expected_pts.insert(expected_pts.size(), pt);
  endfunction

  // Work out the output points caused by one accepted transaction
  function automatic void advance_track(logic signed [31:0] px, logic signed [31:0] py,
                                        logic plast);
    int n;
    int i;
    longint blk;
    longint q_x;
    longint q_y;
    track_pt_t pt;
    n = 0;
    if (!have_anchor || gate_accepts(px, py)) begin
      anchor_x    = px;
      anchor_y    = py;
      have_anchor = 1'b1;
      miss_cnt    = '0;
      if (head_cnt < EDGE_POINTS) begin
        push_point(px, py, 1'b0);
        n++;
        head_cnt++;
      end else begin
        if (hold_fill == EDGE_POINTS) begin
          blk = (block_len_r == 0) ? 1 : longint'(block_len_r);
          sum_x += longint'(hold_x[0]);
          sum_y += longint'(hold_y[0]);
          group_cnt++;
          if (group_cnt >= blk) begin
            q_x = sum_x / longint'(group_cnt);
            q_y = sum_y / longint'(group_cnt);
            push_point(q_x[31:0], q_y[31:0], 1'b1);
            n++;
            sum_x     = 0;
            sum_y     = 0;
            group_cnt = 0;
          end
          for (i = 1; i < EDGE_POINTS; i++) begin
            hold_x[i-1] = hold_x[i];
            hold_y[i-1] = hold_y[i];
          end
          hold_fill--;
        end
        hold_x[hold_fill] = px;
        hold_y[hold_fill] = py;
        hold_fill++;
      end
    end else if (miss_cnt < miss_limit_r) begin
      miss_cnt++;
    end else begin
      anchor_x = px;
      anchor_y = py;
    end

    // Flush the delay line and mark the final point of the track
    if (plast) begin
      for (i = 0; i < hold_fill; i++) begin
        push_point(hold_x[i], hold_y[i], 1'b0);
        n++;
      end
      if (n > 0) begin
        pt = expected_pts[expected_pts.size() - 1];
        pt.last = 1'b1;
        expected_pts[expected_pts.size() - 1] = pt;
      end
      clear_track();
    end
  endfunction

  // Send one point, with random idle cycles ahead of it
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic plast);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pt_in.valid <= 1'b0;
      @(posedge clk);
    end
    pt_in.valid   <= 1'b1;
    pt_in.x_in    <= px;
    pt_in.y_in    <= py;
    pt_in.last_in <= plast;
    do @(posedge clk); while (pt_in.ready !== 1'b1);
    advance_track(px, py, plast);
  endtask

  // Drop valid, wait for every expected point, then let the block settle
  task automatic wait_for_idle();
    pt_in.valid <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      olg_pkg::CFG_BLOCK_LEN:  block_len_r  = data[BL_W-1:0];
      olg_pkg::CFG_MAX_DIST:   max_dist_r   = data[MD_W-1:0];
      olg_pkg::CFG_MISS_LIMIT: miss_limit_r = data[ML_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Gate boundaries, extreme coordinates, single point track, silent last point
  task automatic test_gate_edges();
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    x0 = 32'sh80000000;
    y0 = 32'sh7FFFFFFF;
    send_point(32'sd100, -32'sd200, 1'b1);
    send_point(x0, y0, 1'b0);
    send_point(x0 + 8191, y0, 1'b0);
    send_point(x0 + 8191 + 8192, y0, 1'b0);
    send_point(x0 + 8191 + 6000, y0 - 6000, 1'b0);
    send_point(32'sh7FFFFFFF, 32'sh80000000, 1'b1);
    wait_for_idle();
  endtask

  // Group averages, registers changed mid-track, reference follow, partial group
  task automatic test_group_reconfig();
    int k;
    int i;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    bx = -32'sd100000;
    by = 32'sd70000;
    k  = 0;
    write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'(1048575));
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(2));
    write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'(0));
    for (i = 0; i < 8; i++) begin
      send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
      k++;
    end
    wait_for_idle();
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(4));
    for (i = 0; i < 2; i++) begin
      send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
      k++;
    end
    // lower block_len with a group open
    wait_for_idle();
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(1));
    send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
    k++;
    wait_for_idle();
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(0));
    send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
    k++;
    // zero miss limit: reference follows the first rejected point
    send_point(bx + 3000000, by, 1'b0);
    wait_for_idle();
    write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'(7));
    send_point(bx + 6000000, by, 1'b0);
    send_point(bx + 9000000, by, 1'b0);
    // lower miss_limit below the miss count
    wait_for_idle();
    write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'(1));
    send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
    k++;
    send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
    k++;
    wait_for_idle();
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(255));
    send_point(bx - 13 * k - 7, by + 29 * k - 3, 1'b0);
    send_point(bx + 3000000, by, 1'b1);
    wait_for_idle();
  endtask

  // Random tracks: mostly walks inside the gate, some boundary and noise points
  task automatic run_random_tracks(input int n_items);
    int sent;
    int len;
    int k;
    int kind;
    longint md;
    longint reach;
    longint step;
    longint cx;
    longint cy;
    longint nx;
    longint ny;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      cx  = longint'(int'($urandom()));
      cy  = longint'(int'($urandom()));
      md  = longint'({44'd0, max_dist_r});
      reach = (md * 3) / 4;
      for (k = 0; k < len && sent < n_items; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          nx = longint'(int'($urandom()));
          ny = longint'(int'($urandom()));
        end else if (kind < 16) begin
          step = ($urandom_range(0, 1) == 0) ? md : -md;
          nx = cx + step;
          if (nx > COORD_MAX || nx < COORD_MIN) nx = cx - step;
          ny = cy;
        end else begin
          step = longint'($urandom_range(0, int'(2 * reach))) - reach;
          nx = cx + step;
          if (nx > COORD_MAX || nx < COORD_MIN) nx = cx - step;
          step = longint'($urandom_range(0, int'(2 * reach))) - reach;
          ny = cy + step;
          if (ny > COORD_MAX || ny < COORD_MIN) ny = cy - step;
          cx = nx;
          cy = ny;
        end
        send_point(nx[31:0], ny[31:0], (k == len - 1) || (sent == n_items - 1));
        sent++;
      end
    end
    wait_for_idle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int narrow, input int n_items);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    if (narrow != 0) begin
      write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'(1));
      write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(1));
      write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'(7));
    end else begin
      case ($urandom_range(0, 4))
        0:       write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'(1048575));
        1:       write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'($urandom_range(2, 64)));
        default: write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'($urandom_range(16, 200000)));
      endcase
      write_reg(olg_pkg::CFG_BLOCK_LEN,
                CFG_W'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 6)));
      write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'($urandom_range(0, 7)));
    end
    run_random_tracks(n_items);
  endtask

  // Hold the receiver off while points keep coming, so the block fills and stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    write_reg(olg_pkg::CFG_BLOCK_LEN, CFG_W'(1));
    write_reg(olg_pkg::CFG_MAX_DIST, CFG_W'(1048575));
    write_reg(olg_pkg::CFG_MISS_LIMIT, CFG_W'(3));
    hold_off_requests++;
    run_random_tracks(30);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    pt_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (seen != hold_off_requests) begin
        seen      = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        pt_out.ready <= 1'b0;
        hold_left--;
      end else begin
        pt_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Check each output transaction against the oldest expected point
  always @(posedge clk) begin
    track_pt_t want;
    if (!rst && pt_out.valid === 1'b1 && pt_out.ready === 1'b1) begin
      if (expected_pts.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected output point x=%0d y=%0d avg=%0b last=%0b",
                   pt_out.x_out, pt_out.y_out, pt_out.is_average, pt_out.last_out);
      end else begin
        want = expected_pts.pop_front();
        if (pt_out.x_out !== want.x || pt_out.y_out !== want.y ||
            pt_out.is_average !== want.avg || pt_out.last_out !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("output mismatch: expected x=%0d y=%0d avg=%0b last=%0b",
                     want.x, want.y, want.avg, want.last);
            $display("                 got      x=%0d y=%0d avg=%0b last=%0b",
                     pt_out.x_out, pt_out.y_out, pt_out.is_average, pt_out.last_out);
          end
        end
      end
    end
  end

  // Watchdog: count cycles without any transaction
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (pt_in.valid === 1'b1 && pt_in.ready === 1'b1) ||
        (pt_out.valid === 1'b1 && pt_out.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    failures          = 0;
    send_idle_pct     = 0;
    sink_stall_pct    = 0;
    hold_off_requests = 0;
    block_len_r       = olg_pkg::BLOCK_LEN_RST;
    max_dist_r        = olg_pkg::MAX_DIST_RST;
    miss_limit_r      = olg_pkg::MISS_LIMIT_RST;
    clear_track();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= olg_pkg::CFG_BLOCK_LEN;
    cfg_data      <= '0;
    pt_in.valid   <= 1'b0;
    pt_in.x_in    <= '0;
    pt_in.y_in    <= '0;
    pt_in.last_in <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_gate_edges();
    test_group_reconfig();
    test_output_backpressure();
    test_random_phase(0, 0, 1, 100);
    test_random_phase(72, 0, 0, 100);
    test_random_phase(0, 72, 0, 100);
    test_random_phase(7, 7, 0, 100);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
